// ----- src/fpe_pkg.sv -----
// Package for the FAT12 packed entry access block.
// Holds the operation codes, sequencer states, control bundle and fixed widths.
// No dependencies.
`default_nettype none

package fpe_pkg;

   localparam int ENTRY_W     = 12;
   localparam int CLUSTER_W   = 12;
   localparam int BYTE_ADDR_W = 13;
   localparam int RSV_W       = 16;
   localparam int BPS_W       = 13;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int PROD_W      = RSV_W + BPS_W;
   localparam int OFS_W       = 13;
   localparam int AGW         = PROD_W + 1;

   typedef enum logic [1:0] {
      OP_RD_ENTRY = 2'd0,
      OP_WR_ENTRY = 2'd1,
      OP_WR_BYTE  = 2'd2,
      OP_RD_BYTE  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RESERVED_SECTORS = 8'd0,
      REG_BYTES_PER_SECTOR = 8'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RAW,
      ST_RCAP,
      ST_MUL,
      ST_SUM,
      ST_CHK1,
      ST_CHK2,
      ST_CAP,
      ST_WRA2,
      ST_WRA1,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      AGU_HOLD,
      AGU_RAW,
      AGU_BASE,
      AGU_INC,
      AGU_DEC
   } agu_cmd_type;

   typedef enum logic [1:0] {
      WSEL_RAW,
      WSEL_LOW,
      WSEL_HIGH
   } wsel_type;

   typedef struct packed {
      agu_cmd_type agu_cmd;
      wsel_type    wsel;
      logic        idle;
      logic        mul_en;
      logic        mem_en;
      logic        mem_we;
      logic        cap_b1;
      logic        cap_b2;
      logic        set_err;
      logic        load_rsp;
   } ctrl_type;

endpackage

`default_nettype wire

// ----- src/fpe_ram.sv -----
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module fpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

`default_nettype wire

// ----- src/fpe_agu.sv -----
// Address unit: one shared adder that forms and steps image addresses, plus a range check on the result.
// Depends on fpe_pkg.
`default_nettype none

module fpe_agu import fpe_pkg::*; #(
   parameter int IMAGE_BYTES = 8192
) (
   input  wire logic                   clock,
   input  wire agu_cmd_type            cmd,
   input  wire logic [PROD_W-1:0]      prod,
   input  wire logic [OFS_W-1:0]       offset,
   input  wire logic [BYTE_ADDR_W-1:0] raw_addr,
   output logic      [AGW-1:0]         addr,
   output logic                        out_of_range
);

   logic [AGW-1:0] addr_ff;
   logic [AGW-1:0] addr_in;
   logic [AGW-1:0] opa;
   logic [AGW-1:0] opb;

   always_comb begin
      unique case (cmd)
         AGU_RAW: begin
            opa = AGW'(raw_addr);
            opb = '0;
         end
         AGU_BASE: begin
            opa = AGW'(prod);
            opb = AGW'(offset);
         end
         AGU_INC: begin
            opa = addr_ff;
            opb = AGW'(1);
         end
         AGU_DEC: begin
            opa = addr_ff;
            opb = '1;
         end
         default: begin
            opa = addr_ff;
            opb = '0;
         end
      endcase
      addr_in = opa + opb;
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   assign addr         = addr_ff;
   assign out_of_range = (addr_ff >= AGW'(IMAGE_BYTES));

endmodule

`default_nettype wire

// ----- src/fpe_seq.sv -----
// Sequencer that steps one operation through multiply, address, read and write cycles.
// Depends on fpe_pkg.
`default_nettype none

module fpe_seq import fpe_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   input  wire op_type req_op,
   input  wire op_type op_held,
   input  wire logic   out_of_range,
   input  wire logic   rsp_free,
   output ctrl_type    ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_WR_BYTE || req_op == OP_RD_BYTE) begin
                  state_in = ST_RAW;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_RAW: begin
            if (out_of_range || op_held == OP_WR_BYTE) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_RCAP;
            end
         end
         ST_RCAP: state_in = ST_FIN;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_CHK1;
         ST_CHK1: state_in = out_of_range ? ST_FIN : ST_CHK2;
         ST_CHK2: state_in = out_of_range ? ST_FIN : ST_CAP;
         ST_CAP:  state_in = (op_held == OP_WR_ENTRY) ? ST_WRA2 : ST_FIN;
         ST_WRA2: state_in = ST_WRA1;
         ST_WRA1: state_in = ST_FIN;
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '{agu_cmd: AGU_HOLD, wsel: WSEL_RAW, default: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.idle    = 1'b1;
            ctrl.agu_cmd = AGU_RAW;
         end
         ST_RAW: begin
            if (out_of_range) begin
               ctrl.set_err = 1'b1;
            end else begin
               ctrl.mem_en = 1'b1;
               ctrl.mem_we = (op_held == OP_WR_BYTE);
            end
         end
         ST_RCAP: ctrl.cap_b1 = 1'b1;
         ST_MUL:  ctrl.mul_en = 1'b1;
         ST_SUM:  ctrl.agu_cmd = AGU_BASE;
         ST_CHK1: begin
            if (out_of_range) begin
               ctrl.set_err = 1'b1;
            end else begin
               ctrl.mem_en  = 1'b1;
               ctrl.agu_cmd = AGU_INC;
            end
         end
         ST_CHK2: begin
            ctrl.cap_b1 = 1'b1;
            if (out_of_range) begin
               ctrl.set_err = 1'b1;
            end else begin
               ctrl.mem_en = 1'b1;
            end
         end
         ST_CAP: ctrl.cap_b2 = 1'b1;
         ST_WRA2: begin
            ctrl.mem_en  = 1'b1;
            ctrl.mem_we  = 1'b1;
            ctrl.wsel    = WSEL_HIGH;
            ctrl.agu_cmd = AGU_DEC;
         end
         ST_WRA1: begin
            ctrl.mem_en = 1'b1;
            ctrl.mem_we = 1'b1;
            ctrl.wsel   = WSEL_LOW;
         end
         ST_FIN: ctrl.load_rsp = rsp_free;
         default: ctrl.idle = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/fat12_packed_entry_access_top.sv -----
// Top level of the FAT12 packed entry access block.
// Depends on fpe_pkg, fpe_ram, fpe_agu and fpe_seq.
//
// Usage: the req_ channel carries one operation per word: read or write a
// 12-bit table entry of a cluster, or read or write one raw image byte.
// A word is taken when req_valid is high and req_stall is low; req_stall is
// high while an operation is in progress. Every word yields exactly one rsp_
// word with entry_out, end_of_chain, byte_out and error, handed over when
// rsp_valid is high and rsp_stall is low.
// Steps per word: a raw write accesses the byte; a raw read also captures
// the registered read data; an entry read forms the product, adds the
// entry offset, reads both bytes and captures them; an entry write then
// writes both bytes back. An out of range error ends the word early. The
// steps follow the single-port image RAM, one byte access at a time, and
// the shared address adder that forms the two entry byte addresses in turn.
// A new word is taken in the cycle after the response is loaded. A word may
// enter while the previous response still waits under rsp_stall; a second
// response waits in the sequencer until the output register frees.
// The csr_ port writes reserved_sectors (index 0) and bytes_per_sector
// (index 1) and is always ready; write it only while the block is idle.
// Reset clears the handshake state and sets the registers to 1 and 512.
// The image contents are undefined after reset until loaded by raw writes.
`default_nettype none

module fat12_packed_entry_access_top import fpe_pkg::*; #(
   parameter int IMAGE_BYTES = 8192
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_op,
   input  wire logic [CLUSTER_W-1:0]   req_cluster,
   input  wire logic [ENTRY_W-1:0]     req_entry_in,
   input  wire logic [BYTE_ADDR_W-1:0] req_byte_address,
   input  wire logic [7:0]             req_byte_in,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [ENTRY_W-1:0]          rsp_entry_out,
   output logic                        rsp_end_of_chain,
   output logic [7:0]                  rsp_byte_out,
   output logic                        rsp_error,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(IMAGE_BYTES);

   ctrl_type ctrl;

   logic [RSV_W-1:0]     rsv_ff;
   logic [BPS_W-1:0]     bps_ff;
   op_type               op_ff;
   logic [CLUSTER_W-1:0] cluster_ff;
   logic [ENTRY_W-1:0]   entry_ff;
   logic [7:0]           byte_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [7:0]           b1_ff;
   logic [7:0]           b2_ff;
   logic                 err_ff;
   logic                 rsp_valid_ff;
   logic [ENTRY_W-1:0]   entry_out_ff;
   logic                 eoc_ff;
   logic [7:0]           byte_out_ff;
   logic                 rsp_err_ff;

   logic                 accept;
   logic                 rsp_free;
   logic [OFS_W-1:0]     offset;
   logic [AGW-1:0]       addr;
   logic                 out_of_range;
   logic [7:0]           wdata;
   logic [7:0]           rdata;
   logic [ENTRY_W-1:0]   unpacked;
   logic [ENTRY_W-1:0]   entry_out_in;
   logic [7:0]           byte_out_in;

   assign accept    = req_valid && ctrl.idle;
   assign req_stall = !ctrl.idle;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsv_ff <= RSV_W'(1);
         bps_ff <= BPS_W'(512);
      end else if (csr_valid) begin
         if (csr_index == REG_RESERVED_SECTORS) begin
            rsv_ff <= csr_wdata;
         end else if (csr_index == REG_BYTES_PER_SECTOR) begin
            bps_ff <= csr_wdata[BPS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_type'(req_op);
         cluster_ff <= req_cluster;
         entry_ff   <= req_entry_in;
         byte_ff    <= req_byte_in;
      end
      if (ctrl.mul_en) begin
         prod_ff <= PROD_W'(rsv_ff) * PROD_W'(bps_ff);
      end
      if (ctrl.cap_b1) begin
         b1_ff <= rdata;
      end
      if (ctrl.cap_b2) begin
         b2_ff <= rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= 1'b0;
      end else if (accept) begin
         err_ff <= 1'b0;
      end else if (ctrl.set_err) begin
         err_ff <= 1'b1;
      end
   end

   // Pair k starts at 3k; an odd cluster's first byte is the middle one.
   assign offset = OFS_W'({cluster_ff[CLUSTER_W-1:1], 1'b0})
                 + OFS_W'(cluster_ff[CLUSTER_W-1:1])
                 + OFS_W'(cluster_ff[0]);

   fpe_agu #(
      .IMAGE_BYTES(IMAGE_BYTES)
   ) u_agu (
      .clock       (clock),
      .cmd         (ctrl.agu_cmd),
      .prod        (prod_ff),
      .offset      (offset),
      .raw_addr    (req_byte_address),
      .addr        (addr),
      .out_of_range(out_of_range)
   );

   fpe_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_op      (op_type'(req_op)),
      .op_held     (op_ff),
      .out_of_range(out_of_range),
      .rsp_free    (rsp_free),
      .ctrl        (ctrl)
   );

   // The neighbor entry's nibble is kept from the bytes read just before.
   always_comb begin
      unique case (ctrl.wsel)
         WSEL_LOW: begin
            wdata = cluster_ff[0] ? {entry_ff[3:0], b1_ff[3:0]} : entry_ff[7:0];
         end
         WSEL_HIGH: begin
            wdata = cluster_ff[0] ? entry_ff[11:4] : {b2_ff[7:4], entry_ff[11:8]};
         end
         default: wdata = byte_ff;
      endcase
   end

   fpe_ram #(
      .WIDTH(8),
      .DEPTH(IMAGE_BYTES)
   ) u_image (
      .clock(clock),
      .en   (ctrl.mem_en),
      .we   (ctrl.mem_we),
      .addr (addr[AW-1:0]),
      .wdata(wdata),
      .rdata(rdata)
   );

   always_comb begin
      unpacked     = cluster_ff[0] ? {b2_ff, b1_ff[7:4]} : {b2_ff[3:0], b1_ff};
      entry_out_in = (op_ff == OP_RD_ENTRY && !err_ff) ? unpacked : '0;
      byte_out_in  = (op_ff == OP_RD_BYTE && !err_ff) ? b1_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         entry_out_ff <= entry_out_in;
         eoc_ff       <= &entry_out_in[ENTRY_W-1:3];
         byte_out_ff  <= byte_out_in;
         rsp_err_ff   <= err_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_out    = entry_out_ff;
   assign rsp_end_of_chain = eoc_ff;
   assign rsp_byte_out     = byte_out_ff;
   assign rsp_error        = rsp_err_ff;

endmodule

`default_nettype wire

// ----- tb/tb_fat12_packed_entry_access_top.sv -----
// Self-checking testbench for fat12_packed_entry_access_top.
// Drives raw byte and packed FAT12 entry operations with random idling and checks every
// response against an in-bench image of the table. Depends on fpe_pkg and the block's RTL.
`default_nettype none

module tb_fat12_packed_entry_access_top;
   import fpe_pkg::*;

   localparam int IMAGE_BYTES   = 8192;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 200;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int POOL_DEPTH    = 16;

   typedef struct packed {
      op_type                 op;
      logic [CLUSTER_W-1:0]   cluster;
      logic [ENTRY_W-1:0]     entry_in;
      logic [BYTE_ADDR_W-1:0] byte_address;
      logic [7:0]             byte_in;
   } fat_op_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] entry_out;
      logic               end_of_chain;
      logic [7:0]         byte_out;
      logic               error;
   } fat_answer_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   op_type                 req_op = OP_RD_ENTRY;
   logic [CLUSTER_W-1:0]   req_cluster = '0;
   logic [ENTRY_W-1:0]     req_entry_in = '0;
   logic [BYTE_ADDR_W-1:0] req_byte_address = '0;
   logic [7:0]             req_byte_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ENTRY_W-1:0]     rsp_entry_out;
   logic                   rsp_end_of_chain;
   logic [7:0]             rsp_byte_out;
   logic                   rsp_error;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = REG_RESERVED_SECTORS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Bench copy of the table geometry and of the image contents.
   logic [RSV_W-1:0]       cfg_rsv = 16'd1;
   logic [BPS_W-1:0]       cfg_bps = 13'd512;
   logic [7:0]             fat_image [IMAGE_BYTES];
   bit                     image_loaded [IMAGE_BYTES];

   fat_answer_type         pending_answers [$];
   logic [CLUSTER_W-1:0]   cluster_pool [$];
   int unsigned            words_sent = 0;
   int unsigned            fail_count = 0;
   int unsigned            send_idle_pct = 0;
   int unsigned            rsp_idle_pct = 0;
   logic                   hold_req = 1'b0;
   int                     hold_left = 0;
   int unsigned            cycle_count = 0;

   fat12_packed_entry_access_top #(.IMAGE_BYTES(IMAGE_BYTES)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_cluster      (req_cluster),
      .req_entry_in     (req_entry_in),
      .req_byte_address (req_byte_address),
      .req_byte_in      (req_byte_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_entry_out    (rsp_entry_out),
      .rsp_end_of_chain (rsp_end_of_chain),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_error        (rsp_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // The two bytes that hold a cluster's entry; an odd cluster starts one byte later.
   function automatic void entry_bytes(input logic [CLUSTER_W-1:0] cluster,
                                       output longint unsigned lo_addr,
                                       output longint unsigned hi_addr);
      lo_addr = 64'(cfg_rsv) * 64'(cfg_bps) + 3 * 64'(cluster >> 1) + 64'(cluster[0]);
      hi_addr = lo_addr + 1;
   endfunction

   function automatic fat_answer_type apply_fat_op(input fat_op_type cmd);
      fat_answer_type    ans;
      longint unsigned   lo_addr, hi_addr;
      logic [7:0]        b1, b2;
      ans = '0;
      case (cmd.op)
         OP_RD_ENTRY, OP_WR_ENTRY: begin
            entry_bytes(cmd.cluster, lo_addr, hi_addr);
            if (hi_addr >= IMAGE_BYTES) begin
               ans.error = 1'b1;
            end else begin
               b1 = fat_image[lo_addr];
               b2 = fat_image[hi_addr];
               if (cmd.op == OP_RD_ENTRY) begin
                  ans.entry_out    = cmd.cluster[0] ? {b2, b1[7:4]} : {b2[3:0], b1};
                  ans.end_of_chain = (ans.entry_out >= 12'hFF8);
               end else if (cmd.cluster[0]) begin
                  fat_image[lo_addr] = {cmd.entry_in[3:0], b1[3:0]};
                  fat_image[hi_addr] = cmd.entry_in[11:4];
               end else begin
                  fat_image[lo_addr] = cmd.entry_in[7:0];
                  fat_image[hi_addr] = {b2[7:4], cmd.entry_in[11:8]};
               end
            end
         end
         OP_WR_BYTE: begin
            if (cmd.byte_address >= IMAGE_BYTES) begin
               ans.error = 1'b1;
            end else begin
               fat_image[cmd.byte_address]    = cmd.byte_in;
               image_loaded[cmd.byte_address] = 1'b1;
            end
         end
         default: begin
            if (cmd.byte_address >= IMAGE_BYTES)
               ans.error = 1'b1;
            else
               ans.byte_out = fat_image[cmd.byte_address];
         end
      endcase
      return ans;
   endfunction

   function automatic fat_op_type random_fields();
      fat_op_type cmd;
      cmd.op           = op_type'($urandom_range(3));
      cmd.cluster      = 12'($urandom_range(4095));
      cmd.entry_in     = 12'($urandom_range(4095));
      cmd.byte_address = 13'($urandom_range(8191));
      cmd.byte_in      = 8'($urandom_range(255));
      return cmd;
   endfunction

   function automatic void check_field(input string name, input logic [11:0] want,
                                       input logic [11:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Valid stays high across back-to-back words; it is only lowered for a gap.
   task automatic send_op(input fat_op_type cmd);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_op           <= cmd.op;
      req_cluster      <= cmd.cluster;
      req_entry_in     <= cmd.entry_in;
      req_byte_address <= cmd.byte_address;
      req_byte_in      <= cmd.byte_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_answers.push_back(apply_fat_op(cmd));
      words_sent++;
   endtask

   task automatic load_byte(input logic [BYTE_ADDR_W-1:0] addr, input logic [7:0] data);
      fat_op_type cmd;
      cmd              = random_fields();
      cmd.op           = OP_WR_BYTE;
      cmd.byte_address = addr;
      cmd.byte_in      = data;
      send_op(cmd);
   endtask

   // Bytes that an operation reads must have been loaded first.
   task automatic ensure_loaded(input longint unsigned addr);
      if (addr < IMAGE_BYTES && !image_loaded[addr])
         load_byte(addr[BYTE_ADDR_W-1:0], 8'($urandom_range(255)));
   endtask

   task automatic read_byte(input logic [BYTE_ADDR_W-1:0] addr);
      fat_op_type cmd;
      ensure_loaded(64'(addr));
      cmd              = random_fields();
      cmd.op           = OP_RD_BYTE;
      cmd.byte_address = addr;
      send_op(cmd);
   endtask

   task automatic access_entry(input op_type op, input logic [CLUSTER_W-1:0] cluster,
                               input logic [ENTRY_W-1:0] value);
      fat_op_type      cmd;
      longint unsigned lo_addr, hi_addr;
      entry_bytes(cluster, lo_addr, hi_addr);
      ensure_loaded(lo_addr);
      ensure_loaded(hi_addr);
      cmd          = random_fields();
      cmd.op       = op;
      cmd.cluster  = cluster;
      cmd.entry_in = value;
      send_op(cmd);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_fat_geometry(input logic [RSV_W-1:0] rsv, input logic [BPS_W-1:0] bps);
      csr_valid <= 1'b1;
      csr_index <= REG_RESERVED_SECTORS;
      csr_wdata <= CSR_DATA_W'(rsv);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_rsv   = rsv;
      csr_index <= REG_BYTES_PER_SECTOR;
      csr_wdata <= CSR_DATA_W'(bps);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_bps   = bps;
      csr_valid <= 1'b0;
   endtask

   task automatic random_fat_op();
      op_type                 op;
      logic [CLUSTER_W-1:0]   cluster;
      logic [ENTRY_W-1:0]     value;
      logic [BYTE_ADDR_W-1:0] addr;
      longint unsigned        lo_addr, hi_addr;
      op = op_type'($urandom_range(3));
      if (cluster_pool.size() != 0 && $urandom_range(99) < 60)
         cluster = cluster_pool[$urandom_range(cluster_pool.size() - 1)];
      else
         cluster = 12'($urandom_range(4095));
      // Raw traffic often lands on live entries so that later entry reads see it.
      entry_bytes(cluster, lo_addr, hi_addr);
      if ($urandom_range(99) < 40 && hi_addr < IMAGE_BYTES)
         addr = ($urandom_range(1) != 0) ? hi_addr[BYTE_ADDR_W-1:0] : lo_addr[BYTE_ADDR_W-1:0];
      else
         addr = 13'($urandom_range(8191));
      if ($urandom_range(99) < 20)
         value = 12'hFF8 | 12'($urandom_range(7));
      else
         value = 12'($urandom_range(4095));
      case (op)
         OP_RD_ENTRY: access_entry(op, cluster, value);
         OP_WR_ENTRY: begin
            access_entry(op, cluster, value);
            cluster_pool.push_back(cluster);
            if (cluster_pool.size() > POOL_DEPTH)
               void'(cluster_pool.pop_front());
         end
         OP_WR_BYTE: load_byte(addr, 8'($urandom_range(255)));
         default: read_byte(addr);
      endcase
   endtask

   task automatic test_raw_bytes();
      load_byte(13'h0000, 8'h00);
      load_byte(13'h1FFF, 8'hFF);
      load_byte(13'h1555, 8'hAA);
      load_byte(13'h0AAA, 8'h55);
      read_byte(13'h0000);
      read_byte(13'h1FFF);
      read_byte(13'h1555);
      read_byte(13'h0AAA);
   endtask

   // Even and odd clusters share a middle byte; each write must keep the other nibble.
   task automatic test_entry_packing();
      access_entry(OP_WR_ENTRY, 12'd0, 12'hFFF);
      access_entry(OP_WR_ENTRY, 12'd1, 12'h000);
      access_entry(OP_RD_ENTRY, 12'd0, 12'h5A5);
      access_entry(OP_RD_ENTRY, 12'd1, 12'hA5A);
      access_entry(OP_WR_ENTRY, 12'd1, 12'hFF8);
      access_entry(OP_RD_ENTRY, 12'd0, 12'h000);
      access_entry(OP_RD_ENTRY, 12'd1, 12'hFFF);
      access_entry(OP_WR_ENTRY, 12'hFFE, 12'hFF7);
      access_entry(OP_WR_ENTRY, 12'hFFF, 12'hABC);
      access_entry(OP_RD_ENTRY, 12'hFFE, 12'h000);
      access_entry(OP_RD_ENTRY, 12'hFFF, 12'h000);
   endtask

   task automatic test_out_of_range();
      wait_until_idle();
      // Table at 6144: cluster 1364 ends on the last byte, cluster 1365 runs one past it.
      set_fat_geometry(16'd3, 13'd2048);
      access_entry(OP_RD_ENTRY, 12'd1364, 12'h000);
      access_entry(OP_WR_ENTRY, 12'd1365, 12'h123);
      access_entry(OP_RD_ENTRY, 12'd4095, 12'h000);
      wait_until_idle();
      set_fat_geometry(16'hFFFF, 13'd4096);
      access_entry(OP_RD_ENTRY, 12'd0, 12'h000);
      access_entry(OP_WR_ENTRY, 12'd4095, 12'hFFF);
      wait_until_idle();
      set_fat_geometry(16'd0, 13'd0);
      access_entry(OP_WR_ENTRY, 12'd1, 12'hFFC);
      access_entry(OP_RD_ENTRY, 12'd1, 12'h000);
      wait_until_idle();
      set_fat_geometry(16'd1, 13'd512);
   endtask

   task automatic test_random_traffic(input int unsigned words);
      int unsigned first_word;
      first_word = words_sent;
      while (words_sent - first_word < words) begin
         wait_until_idle();
         case ($urandom_range(7))
            0: set_fat_geometry(16'd1, 13'd512);
            1: set_fat_geometry(16'd0, 13'd4096);
            2: set_fat_geometry(16'd2, 13'd1024);
            3: set_fat_geometry(16'd3, 13'd2048);
            4: set_fat_geometry(16'd5, 13'd1229);
            5: set_fat_geometry(16'd1, 13'd4096);
            6: set_fat_geometry(16'd65535, 13'd0);
            default: set_fat_geometry(16'd4, 13'd512);
         endcase
         for (int i = 0; i < 60 && words_sent - first_word < words; i++)
            random_fat_op();
      end
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_output_backpressure();
      wait_until_idle();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      repeat (16) random_fat_op();
   endtask

   always @(posedge clock) begin
      if (hold_req)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
      rsp_stall <= hold_req || hold_left > 1 || ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin : check_answers
      fat_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("response word with no operation outstanding");
            fail_count++;
         end else begin
            want = pending_answers.pop_front();
            check_field("entry_out", want.entry_out, rsp_entry_out);
            check_field("end_of_chain", 12'(want.end_of_chain), 12'(rsp_end_of_chain));
            check_field("byte_out", 12'(want.byte_out), 12'(rsp_byte_out));
            check_field("error", 12'(want.error), 12'(rsp_error));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("fat12_packed_entry_access_top regression: fail");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_raw_bytes();
      test_entry_packing();
      test_out_of_range();
      send_idle_pct = 18;
      rsp_idle_pct  = 69;
      test_random_traffic(290);
      send_idle_pct = 69;
      rsp_idle_pct  = 18;
      test_random_traffic(290);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_traffic(290);
      test_output_backpressure();
      wait_until_idle();
      if (fail_count == 0)
         $display("fat12_packed_entry_access_top regression: pass");
      else
         $display("fat12_packed_entry_access_top regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
